// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and the digit-to-character function for the radix converter.
package itoa_pkg;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned RADIX_W      = 6;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned DIGIT_W      = 5;
  localparam int unsigned BITS_PER_CYC = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd32;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 5'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  typedef struct packed {
    logic               bad;
    logic               neg;
    logic [RADIX_W-1:0] radix;
  } job_ctl_t;

  localparam int unsigned JOB_CTL_W = $bits(job_ctl_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PRIME,
    S_SIGN,
    S_EMIT,
    S_BAD
  } back_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < DECIMAL_DIGITS) begin
      return CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    end
    return CH_A + {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_W'(d - DECIMAL_DIGITS)};
  endfunction

endpackage

// ===== rtl/integer_to_ascii_radix.sv =====
// Top level: integer to ASCII conversion in radix 2 to 32, one character per strobe.
// A word taken on start waits in the queue until the back end is idle and pops it. The back
// end divides the magnitude repeatedly in the shared 8-bit-per-cycle divider, storing each
// remainder as a digit, then primes the digit read, sends a minus sign if negative and then
// the digits. A bad radix gives its one result instead. The back end converts one word at a
// time; a two-word queue lets start be taken meanwhile.
// Characters go out one per cycle and the receiver cannot stall. Reset clears all control.
module integer_to_ascii_radix
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [RADIX_W-1:0] radix_i,
  input  logic               is_signed_i,
  output logic               strobe_o,
  output logic [CHAR_W-1:0]  character_o,
  output logic               last_o,
  output logic               bad_radix_o
);

  localparam int unsigned JOB_W = JOB_CTL_W + VALUE_BITS;

  job_ctl_t              front_ctl;
  logic [VALUE_BITS-1:0] front_mag;
  job_ctl_t              back_ctl;
  logic [VALUE_BITS-1:0] back_mag;
  logic                  push;
  logic                  pop;
  logic                  q_full;
  logic                  q_empty;
  logic [JOB_W-1:0]      q_out;

  itoa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .value_i    (value_i),
    .radix_i    (radix_i),
    .is_signed_i(is_signed_i),
    .ctl_o      (front_ctl),
    .mag_o      (front_mag)
  );

  assign push = start && !q_full;
  assign busy = q_full;

  itoa_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({front_ctl, front_mag}),
    .pop_i  (pop),
    .data_o (q_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  assign back_ctl = q_out[JOB_W-1:VALUE_BITS];
  assign back_mag = q_out[VALUE_BITS-1:0];

  itoa_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!q_empty),
    .job_ctl_i  (back_ctl),
    .job_mag_i  (back_mag),
    .job_pop_o  (pop),
    .strobe_o   (strobe_o),
    .character_o(character_o),
    .last_o     (last_o),
    .bad_radix_o(bad_radix_o)
  );

  a_bad_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && bad_radix_o |-> last_o && (character_o == CH_NONE))
    else $error("bad radix result not a lone null character");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("character strobed right after a last character");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !bad_radix_o && (character_o == CH_MINUS) |-> !last_o)
    else $error("minus sign marked as last character");

  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a word taken");

endmodule

// ===== rtl/itoa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module itoa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/itoa_queue.sv =====
// Short job queue between the classifying front end and the conversion back end.
module itoa_queue
  import itoa_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

// ===== rtl/itoa_front.sv =====
// Front end: checks the radix, finds the sign and forms the unsigned magnitude.
module itoa_front
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic [VALUE_W-1:0]    value_i,
  input  logic [RADIX_W-1:0]    radix_i,
  input  logic                  is_signed_i,
  output job_ctl_t              ctl_o,
  output logic [VALUE_BITS-1:0] mag_o
);

  logic [VALUE_BITS-1:0] v;

  if (VALUE_BITS <= VALUE_W) begin : g_trunc
    assign v = value_i[VALUE_BITS-1:0];
  end else begin : g_extend
    assign v = {{(VALUE_BITS-VALUE_W){1'b0}}, value_i};
  end

  always_comb begin
    ctl_o.bad   = !(radix_i inside {[RADIX_MIN:RADIX_MAX]});
    ctl_o.neg   = is_signed_i && v[VALUE_BITS-1];
    ctl_o.radix = radix_i;
    // unsigned negate, so the most negative value keeps its full magnitude
    mag_o       = ctl_o.neg ? (~v + 1'b1) : v;
  end

endmodule

// ===== rtl/itoa_back.sv =====
// Back end: digit extraction by iterative division, digit stack, and character output.
module itoa_back
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  job_ctl_t              job_ctl_i,
  input  logic [VALUE_BITS-1:0] job_mag_i,
  output logic                  job_pop_o,
  output logic                  strobe_o,
  output logic [CHAR_W-1:0]     character_o,
  output logic                  last_o,
  output logic                  bad_radix_o
);

  localparam int unsigned DIV_STEPS = (VALUE_BITS + BITS_PER_CYC - 1) / BITS_PER_CYC;
  localparam int unsigned DIV_W     = DIV_STEPS * BITS_PER_CYC;
  localparam int unsigned STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int unsigned AW        = $clog2(VALUE_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  back_state_e state_q, state_d;

  logic [DIV_W-1:0]   work_q, work_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               neg_q, neg_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [AW:0]        nd_q, nd_d;
  logic [AW-1:0]      ptr_q, ptr_d;

  logic [DIV_W-1:0]   div_quo;
  logic [RADIX_W-1:0] div_rem;
  logic               div_last;
  logic               quo_zero;

  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  // Eight restoring-division bits per cycle; remainder stays below the radix.
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    logic [DIV_W-1:0]   w;
    r = rem_q;
    w = work_q;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      t = {r, w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, radix_q}) begin
        t    = t - {1'b0, radix_q};
        w[0] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    div_rem = r;
    div_quo = w;
  end

  assign div_last = (step_q == LAST_STEP);
  assign quo_zero = (div_quo == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = job_ctl_i.bad ? S_BAD : S_DIV;
        end
      end
      S_DIV: begin
        if (div_last && quo_zero) begin
          state_d = S_PRIME;
        end
      end
      S_PRIME: begin
        state_d = neg_q ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (ptr_q == '0) begin
          state_d = S_IDLE;
        end
      end
      S_BAD: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs and memory control
  always_comb begin
    job_pop_o   = 1'b0;
    strobe_o    = 1'b0;
    character_o = CH_NONE;
    last_o      = 1'b0;
    bad_radix_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q - 1'b1;
    case (state_q)
      S_IDLE: begin
        job_pop_o = job_valid_i;
      end
      S_DIV: begin
        ram_we = div_last;
      end
      S_PRIME: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
      end
      S_SIGN: begin
        strobe_o    = 1'b1;
        character_o = CH_MINUS;
      end
      S_EMIT: begin
        strobe_o    = 1'b1;
        character_o = digit_char(ram_rdata);
        last_o      = (ptr_q == '0);
        ram_re      = (ptr_q != '0);
      end
      S_BAD: begin
        strobe_o    = 1'b1;
        last_o      = 1'b1;
        bad_radix_o = 1'b1;
      end
      default: begin
        strobe_o = 1'b0;
      end
    endcase
  end

  // Datapath
  always_comb begin
    work_d  = work_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    step_d  = step_q;
    nd_d    = nd_q;
    ptr_d   = ptr_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          work_d  = DIV_W'(job_mag_i);
          rem_d   = '0;
          radix_d = job_ctl_i.radix;
          neg_d   = job_ctl_i.neg;
          step_d  = '0;
          nd_d    = '0;
        end
      end
      S_DIV: begin
        work_d = div_quo;
        rem_d  = div_rem;
        step_d = step_q + 1'b1;
        if (div_last) begin
          // digit done: push it and restart on the quotient
          nd_d   = nd_q + 1'b1;
          ptr_d  = nd_q[AW-1:0];
          rem_d  = '0;
          step_d = '0;
        end
      end
      S_EMIT: begin
        if (ptr_q != '0) begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      nd_q    <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      nd_q    <= nd_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    neg_q   <= neg_d;
  end

  itoa_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(nd_q[AW-1:0]),
    .wdata_i(div_rem[DIGIT_W-1:0]),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

// ===== verif/tb.sv =====
// Testbench for integer_to_ascii_radix: random and directed conversions checked per character.
`timescale 1ns / 100ps

module tb;
  import itoa_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_WORDS = 360;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               is_signed;
    int unsigned        gap;
    bit                 hold_off;
  } conv_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } char_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [VALUE_W-1:0] value_i = '0;
  logic [RADIX_W-1:0] radix_i = '0;
  logic is_signed_i = 1'b0;
  logic busy;
  logic strobe_o;
  logic [CHAR_W-1:0] character_o;
  logic last_o;
  logic bad_radix_o;

  conv_word_t  pending_words[$];
  char_res_t   expected_chars[$];
  conv_word_t  cur_word;
  bit          holding = 1'b0;
  int unsigned gap_waited = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          burst = 1'b0;

  integer_to_ascii_radix dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .is_signed_i (is_signed_i),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_o      (last_o),
    .bad_radix_o (bad_radix_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Expected characters of one conversion, most significant first.
  task automatic predict_chars(input conv_word_t w);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] rad;
    logic [VALUE_W-1:0] rem;
    logic [CHAR_W-1:0]  digits[$];
    bit                 neg;
    if (w.radix < RADIX_MIN || w.radix > RADIX_MAX) begin
      expected_chars.push_back('{ch: CH_NONE, last: 1'b1, bad: 1'b1});
      return;
    end
    rad = VALUE_W'(w.radix);
    neg = w.is_signed && w.value[VALUE_W-1];
    mag = neg ? (~w.value + 1'b1) : w.value;
    do begin
      rem = mag % rad;
      if (rem < VALUE_W'(DECIMAL_DIGITS)) begin
        digits.push_front(CH_ZERO + CHAR_W'(rem));
      end else begin
        digits.push_front(CH_A + CHAR_W'(rem - VALUE_W'(DECIMAL_DIGITS)));
      end
      mag = mag / rad;
    end while (mag != 0);
    if (neg) begin
      expected_chars.push_back('{ch: CH_MINUS, last: 1'b0, bad: 1'b0});
    end
    for (int i = 0; i < digits.size(); i++) begin
      expected_chars.push_back('{ch: digits[i], last: (i == digits.size() - 1), bad: 1'b0});
    end
  endtask

  task automatic add_word(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
                          input logic s, input bit hold_off);
    conv_word_t w;
    if ($urandom_range(0, 19) == 0) begin
      burst = ~burst;
    end
    w.value     = v;
    w.radix     = r;
    w.is_signed = s;
    w.gap       = burst ? 0 : $urandom_range(0, 14);
    w.hold_off  = hold_off;
    pending_words.push_back(w);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return VALUE_W'($urandom_range(0, 255));
      2: return VALUE_W'($urandom_range(0, 40));
      3: return {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 3));
      4: return {1'b1, {(VALUE_W-1){1'b0}}} + VALUE_W'($urandom_range(0, 3));
      default: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                     : RADIX_W'($urandom_range(33, 63));
      1: begin
        case ($urandom_range(0, 3))
          0: return RADIX_MIN;
          1: return RADIX_W'(10);
          2: return RADIX_W'(16);
          default: return RADIX_MAX;
        endcase
      end
      default: return RADIX_W'($urandom_range(2, 32));
    endcase
  endfunction

  // Driver: offer one word at a time, take it when start meets a low busy.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      value_i     <= '0;
      radix_i     <= '0;
      is_signed_i <= 1'b0;
      holding     = 1'b0;
      gap_waited  = 0;
    end else begin
      if (start && !busy) begin
        predict_chars(cur_word);
        holding = 1'b0;
      end
      if (!holding && pending_words.size() != 0) begin
        if (gap_waited < pending_words[0].gap) begin
          gap_waited++;
        end else if (!pending_words[0].hold_off || expected_chars.size() == 0) begin
          cur_word    = pending_words.pop_front();
          gap_waited  = 0;
          holding     = 1'b1;
          value_i     <= cur_word.value;
          radix_i     <= cur_word.radix;
          is_signed_i <= cur_word.is_signed;
        end
      end
      start <= holding;
    end
  end

  // Monitor: every strobe carries one character, checked against the oldest expectation.
  always @(posedge clk_i) begin
    char_res_t exp_c;
    if (rst_ni && strobe_o) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b bad %b",
                                  character_o, last_o, bad_radix_o));
      end else begin
        exp_c = expected_chars.pop_front();
        if (character_o !== exp_c.ch) begin
          report_mismatch($sformatf("character %h, want %h", character_o, exp_c.ch));
        end
        if (last_o !== exp_c.last) begin
          report_mismatch($sformatf("last %b, want %b (char %h)", last_o, exp_c.last,
                                    exp_c.ch));
        end
        if (bad_radix_o !== exp_c.bad) begin
          report_mismatch($sformatf("bad_radix %b, want %b", bad_radix_o, exp_c.bad));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word or character for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Directed: zero, extremes, most negative value, digit boundaries, bad radices.
    add_word(32'd0, 6'd10, 1'b0, 1'b0);
    add_word(32'd0, 6'd2, 1'b1, 1'b0);
    add_word(32'hFFFF_FFFF, 6'd2, 1'b0, 1'b0);
    add_word(32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0);
    add_word(32'hFFFF_FFFF, 6'd10, 1'b1, 1'b0);
    add_word(32'h8000_0000, 6'd10, 1'b1, 1'b1);
    add_word(32'h8000_0000, 6'd2, 1'b1, 1'b0);
    add_word(32'h8000_0000, 6'd2, 1'b0, 1'b0);
    add_word(32'h7FFF_FFFF, 6'd16, 1'b1, 1'b0);
    add_word(32'd31, 6'd32, 1'b0, 1'b0);
    add_word(32'd9, 6'd10, 1'b0, 1'b0);
    add_word(32'd10, 6'd11, 1'b0, 1'b0);
    add_word(32'd12345, 6'd10, 1'b0, 1'b0);
    add_word(32'hDEAD_BEEF, 6'd16, 1'b0, 1'b0);
    add_word(32'hDEAD_BEEF, 6'd16, 1'b1, 1'b0);
    add_word(32'd4095, 6'd8, 1'b0, 1'b0);
    add_word(32'hFFFF_FFFB, 6'd3, 1'b1, 1'b0);
    add_word(32'd1000, 6'd7, 1'b0, 1'b0);
    add_word(32'd55, 6'd0, 1'b0, 1'b0);
    add_word(32'd55, 6'd1, 1'b1, 1'b0);
    add_word(32'h8000_0000, 6'd33, 1'b1, 1'b0);
    add_word(32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1);
    add_word(32'd100, 6'd36, 1'b0, 1'b0);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      add_word(pick_value(), pick_radix(), 1'($urandom_range(0, 1)),
               $urandom_range(0, 39) == 0);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || holding || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
